/* sv/assert_macros.svh */
// Assertion macros for the CHIP-8 execute block.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/c8ie_pkg.sv */
// Shared types and constants for the CHIP-8 execute block.
// No dependencies.
`timescale 1ns / 1ps

package c8ie_pkg;

  localparam int ADDR_W = 12;
  localparam int DATA_W = 8;
  localparam int OP_W   = 16;
  localparam int RIDX_W = 4;
  localparam int REG_CNT = 16;

  localparam logic [RIDX_W-1:0] REG_V0 = 4'h0;
  localparam logic [RIDX_W-1:0] REG_VF = 4'hF;

  // Opcode groups (top nibble)
  localparam logic [3:0] GRP_JUMP     = 4'h1;
  localparam logic [3:0] GRP_SKIP_EQ  = 4'h3;
  localparam logic [3:0] GRP_SKIP_NE  = 4'h4;
  localparam logic [3:0] GRP_SKIP_REQ = 4'h5;
  localparam logic [3:0] GRP_LOAD     = 4'h6;
  localparam logic [3:0] GRP_ADD      = 4'h7;
  localparam logic [3:0] GRP_ALU      = 4'h8;
  localparam logic [3:0] GRP_SKIP_RNE = 4'h9;
  localparam logic [3:0] GRP_LOAD_I   = 4'hA;
  localparam logic [3:0] GRP_JUMP_V0  = 4'hB;
  localparam logic [3:0] GRP_RAND     = 4'hC;
  localparam logic [3:0] GRP_MISC     = 4'hF;

  // 8XYN functions (low nibble)
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // FXNN forms (low byte)
  localparam logic [7:0] MISC_GET_DELAY = 8'h07;
  localparam logic [7:0] MISC_SET_DELAY = 8'h15;

  localparam logic [7:0] RAND_MOD = 8'hFF;

  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] index;
    logic [DATA_W-1:0] delay;
    logic [DATA_W-1:0] v0;
    logic [DATA_W-1:0] vf;
  } arch_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic              reg_write;
    logic [RIDX_W-1:0] reg_index;
    logic [DATA_W-1:0] reg_value;
    logic [DATA_W-1:0] flag_value;
    logic [ADDR_W-1:0] address_value;
    logic [DATA_W-1:0] timer_value;
    logic              unsupported;
  } exec_result_t;

endpackage

/* sv/c8ie_regfile.sv */
// V register file: 16 x 8 memory, one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on c8ie_pkg.
`timescale 1ns / 1ps

module c8ie_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [c8ie_pkg::RIDX_W-1:0]   waddr,
  input  logic [c8ie_pkg::DATA_W-1:0]   wdata,
  input  logic                          re,
  input  logic [c8ie_pkg::RIDX_W-1:0]   raddr_a,
  input  logic [c8ie_pkg::RIDX_W-1:0]   raddr_b,
  output logic [c8ie_pkg::DATA_W-1:0]   rdata_a,
  output logic [c8ie_pkg::DATA_W-1:0]   rdata_b
);
  import c8ie_pkg::*;

  logic [DATA_W-1:0]  mem [REG_CNT];
  logic [REG_CNT-1:0] valid;
  logic [DATA_W-1:0]  data_a;
  logic [DATA_W-1:0]  data_b;
  logic               hit_a;
  logic               hit_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      data_a <= mem[raddr_a];
      data_b <= mem[raddr_b];
      hit_a  <= valid[raddr_a];
      hit_b  <= valid[raddr_b];
    end
  end

  assign rdata_a = hit_a ? data_a : '0;
  assign rdata_b = hit_b ? data_b : '0;

endmodule

/* sv/c8ie_alu.sv */
// Single-pass instruction decode and execute for one CHIP-8 opcode.
// Produces the result item, which also carries the next architectural state.
// Depends on c8ie_pkg.
`timescale 1ns / 1ps

module c8ie_alu (
  input  logic [c8ie_pkg::OP_W-1:0]   op,
  input  logic [c8ie_pkg::DATA_W-1:0] rnd,
  input  logic [c8ie_pkg::DATA_W-1:0] vx,
  input  logic [c8ie_pkg::DATA_W-1:0] vy,
  input  c8ie_pkg::arch_state_t       st,
  output c8ie_pkg::exec_result_t      res
);
  import c8ie_pkg::*;

  logic [3:0]        grp;
  logic [3:0]        fn;
  logic [RIDX_W-1:0] x;
  logic [7:0]        nn;
  logic [ADDR_W-1:0] nnn;
  logic [ADDR_W-1:0] pc2;
  logic [ADDR_W-1:0] pc4;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] rnd_red;
  logic [DATA_W-1:0] timer_w;
  logic              wr;
  logic              fwr;
  logic              flag;
  logic              unsup;
  logic              set_delay;
  logic [DATA_W-1:0] val;
  logic [ADDR_W-1:0] npc;
  logic [ADDR_W-1:0] idx;

  assign grp = op[15:12];
  assign x   = op[11:8];
  assign fn  = op[3:0];
  assign nn  = op[7:0];
  assign nnn = op[ADDR_W-1:0];
  assign pc2 = st.pc + ADDR_W'(2);
  assign pc4 = st.pc + ADDR_W'(4);
  assign sum = {1'b0, vx} + {1'b0, vy};
  assign rnd_red = (rnd == RAND_MOD) ? '0 : rnd;

  always_comb begin
    wr        = 1'b0;
    fwr       = 1'b0;
    flag      = 1'b0;
    unsup     = 1'b0;
    set_delay = 1'b0;
    val       = '0;
    npc       = pc2;
    idx       = st.index;
    unique case (grp)
      GRP_JUMP:     npc = nnn;
      GRP_SKIP_EQ:  if (vx == nn) npc = pc4;
      GRP_SKIP_NE:  if (vx != nn) npc = pc4;
      GRP_SKIP_REQ: if (vx == vy) npc = pc4;
      GRP_LOAD: begin
        wr  = 1'b1;
        val = nn;
      end
      GRP_ADD: begin
        wr  = 1'b1;
        val = vx + nn;
      end
      GRP_ALU: begin
        wr = 1'b1;
        unique case (fn)
          ALU_MOV: val = vy;
          ALU_OR:  val = vx | vy;
          ALU_AND: val = vx & vy;
          ALU_XOR: val = vx ^ vy;
          ALU_ADD: begin
            val  = sum[DATA_W-1:0];
            fwr  = 1'b1;
            flag = sum[DATA_W];
          end
          ALU_SUB: begin
            val  = vx - vy;
            fwr  = 1'b1;
            flag = (vx >= vy);
          end
          ALU_SHR: begin
            val  = vy >> 1;
            fwr  = 1'b1;
            flag = vy[0];
          end
          ALU_SUBN: begin
            val  = vy - vx;
            fwr  = 1'b1;
            flag = (vy >= vx);
          end
          ALU_SHL: begin
            val  = vy << 1;
            fwr  = 1'b1;
            flag = vy[DATA_W-1];
          end
          default: begin
            wr    = 1'b0;
            unsup = 1'b1;
          end
        endcase
      end
      GRP_SKIP_RNE: if (vx != vy) npc = pc4;
      GRP_LOAD_I:   idx = nnn;
      GRP_JUMP_V0:  npc = nnn + ADDR_W'(st.v0);
      GRP_RAND: begin
        wr  = 1'b1;
        val = rnd_red & nn;
      end
      GRP_MISC: begin
        if (nn == MISC_GET_DELAY) begin
          wr  = 1'b1;
          val = st.delay;
        end else if (nn == MISC_SET_DELAY) begin
          set_delay = 1'b1;
        end else begin
          unsup = 1'b1;
        end
      end
      default: unsup = 1'b1;
    endcase
  end

  assign timer_w = set_delay ? vx : st.delay;

  always_comb begin
    res.next_pc       = npc;
    res.reg_write     = wr;
    res.reg_index     = x;
    res.reg_value     = val;
    res.address_value = idx;
    res.timer_value   = (timer_w != '0) ? timer_w - DATA_W'(1) : '0;
    res.unsupported   = unsup;
    priority if (fwr) begin
      res.flag_value = {{(DATA_W-1){1'b0}}, flag};
    end else if (wr && x == REG_VF) begin
      res.flag_value = val;
    end else begin
      res.flag_value = st.vf;
    end
  end

endmodule

/* sv/chip8_instruction_execute.sv */
// CHIP-8 instruction execute block: one opcode and one random byte in, one
// result out per transaction. Sustains one instruction per clock while the
// result side is not stalled; the register file is read at the accepting
// edge, then the execute stage registers the result and commits PC, I, VF,
// timer and VX. The execute stage sets the rate. V registers read as zero
// after reset through per-entry valid bits, so there is no clearing pass.
// Depends on c8ie_pkg, c8ie_regfile, c8ie_alu and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chip8_instruction_execute #(
  parameter int unsigned PROGRAM_START = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [c8ie_pkg::OP_W-1:0]     opcode,
  input  logic [c8ie_pkg::DATA_W-1:0]   rand_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [c8ie_pkg::ADDR_W-1:0]   next_pc,
  output logic                          reg_write,
  output logic [c8ie_pkg::RIDX_W-1:0]   reg_index,
  output logic [c8ie_pkg::DATA_W-1:0]   reg_value,
  output logic [c8ie_pkg::DATA_W-1:0]   flag_value,
  output logic [c8ie_pkg::ADDR_W-1:0]   address_value,
  output logic [c8ie_pkg::DATA_W-1:0]   timer_value,
  output logic                          unsupported
);
  import c8ie_pkg::*;

  logic              exec_valid;
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] rnd_q;
  logic              adv;
  logic              exec_fire;
  logic              in_fire;

  logic [ADDR_W-1:0] pc;
  logic [ADDR_W-1:0] index;
  logic [DATA_W-1:0] delay;
  logic [DATA_W-1:0] v0;
  logic [DATA_W-1:0] vf;

  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic              fwd_a;
  logic              fwd_b;
  logic [DATA_W-1:0] fwd_data;
  logic [DATA_W-1:0] vx;
  logic [DATA_W-1:0] vy;

  arch_state_t       st;
  exec_result_t      res;
  exec_result_t      res_q;

  assign adv       = !out_valid || out_ready;
  assign exec_fire = exec_valid && adv;
  assign in_ready  = !exec_valid || adv;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
    end else if (in_fire) begin
      exec_valid <= 1'b1;
    end else if (exec_fire) begin
      exec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q     <= opcode;
      rnd_q    <= rand_byte;
      fwd_a    <= exec_fire && res.reg_write && res.reg_index == opcode[11:8];
      fwd_b    <= exec_fire && res.reg_write && res.reg_index == opcode[7:4];
      fwd_data <= res.reg_value;
    end
  end

  c8ie_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (exec_fire && res.reg_write),
    .waddr   (res.reg_index),
    .wdata   (res.reg_value),
    .re      (in_fire),
    .raddr_a (opcode[11:8]),
    .raddr_b (opcode[7:4]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // VF lives in its own register; the memory copy of entry F is never read.
  assign vx = (op_q[11:8] == REG_VF) ? vf : (fwd_a ? fwd_data : rdata_a);
  assign vy = (op_q[7:4] == REG_VF)  ? vf : (fwd_b ? fwd_data : rdata_b);

  always_comb begin
    st.pc    = pc;
    st.index = index;
    st.delay = delay;
    st.v0    = v0;
    st.vf    = vf;
  end

  c8ie_alu u_alu (
    .op  (op_q),
    .rnd (rnd_q),
    .vx  (vx),
    .vy  (vy),
    .st  (st),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= ADDR_W'(PROGRAM_START);
      index <= '0;
      delay <= '0;
      v0    <= '0;
      vf    <= '0;
    end else if (exec_fire) begin
      pc    <= res.next_pc;
      index <= res.address_value;
      delay <= res.timer_value;
      vf    <= res.flag_value;
      if (res.reg_write && res.reg_index == REG_V0) begin
        v0 <= res.reg_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_q <= res;
    end
  end

  assign next_pc       = res_q.next_pc;
  assign reg_write     = res_q.reg_write;
  assign reg_index     = res_q.reg_index;
  assign reg_value     = res_q.reg_value;
  assign flag_value    = res_q.flag_value;
  assign address_value = res_q.address_value;
  assign timer_value   = res_q.timer_value;
  assign unsupported   = res_q.unsupported;

  `ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid && in_ready)
  `ASSERT_IMPLIES(a_stall_when_full, clk, rst, !in_ready, out_valid && !out_ready)
  `ASSERT_IMPLIES(a_unsup_no_write, clk, rst, out_valid && unsupported, !reg_write)
  `ASSERT_IMPLIES(a_result_source, clk, rst, $rose(out_valid), $past(exec_valid))

endmodule

/* tb/tb_chip8_instruction_execute.sv */
// Self-checking testbench for chip8_instruction_execute: directed opcode table, then
// weighted random instructions, checked against an in-bench CHIP-8 execution model.
// Depends on c8ie_pkg and the chip8_instruction_execute RTL.
`timescale 1ns / 1ps

module tb_chip8_instruction_execute;
  import c8ie_pkg::*;

  localparam int N_RAND     = 450;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] rnd;
    bit                typed;
    exec_result_t      want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     opcode;
  logic [DATA_W-1:0]   rand_byte;
  logic                out_valid;
  logic                out_ready;
  logic [ADDR_W-1:0]   next_pc;
  logic                reg_write;
  logic [RIDX_W-1:0]   reg_index;
  logic [DATA_W-1:0]   reg_value;
  logic [DATA_W-1:0]   flag_value;
  logic [ADDR_W-1:0]   address_value;
  logic [DATA_W-1:0]   timer_value;
  logic                unsupported;

  // execution model state
  logic [ADDR_W-1:0]   model_pc;
  logic [DATA_W-1:0]   model_v [REG_CNT];
  logic [ADDR_W-1:0]   model_i;
  logic [DATA_W-1:0]   model_delay;

  exec_result_t        exec_results_q[$];
  bit                  typed_valid;
  exec_result_t        typed_result;
  int                  err_cnt;
  int                  idle_cycles;
  int                  send_idle;
  int                  recv_idle;
  bit                  hold_req;
  bit                  hold_done;

  chip8_instruction_execute #(
    .PROGRAM_START(512)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .rand_byte     (rand_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_pc       (next_pc),
    .reg_write     (reg_write),
    .reg_index     (reg_index),
    .reg_value     (reg_value),
    .flag_value    (flag_value),
    .address_value (address_value),
    .timer_value   (timer_value),
    .unsupported   (unsupported)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic exec_result_t execute_opcode(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] rnd);
    logic [3:0]        grp;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [3:0]        n;
    logic [7:0]        nn;
    logic [ADDR_W-1:0] nnn;
    logic [DATA_W-1:0] vx;
    logic [DATA_W-1:0] vy;
    logic [ADDR_W-1:0] npc;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] flag;
    logic              wr;
    logic              fwr;
    logic              unsup;
    exec_result_t      res;
    grp   = op[15:12];
    x     = op[11:8];
    y     = op[7:4];
    n     = op[3:0];
    nn    = op[7:0];
    nnn   = op[11:0];
    vx    = model_v[x];
    vy    = model_v[y];
    npc   = model_pc + 12'd2;
    val   = '0;
    flag  = '0;
    wr    = 1'b0;
    fwr   = 1'b0;
    unsup = 1'b0;
    case (grp)
      GRP_JUMP:     npc = nnn;
      GRP_SKIP_EQ:  if (vx == nn) npc = model_pc + 12'd4;
      GRP_SKIP_NE:  if (vx != nn) npc = model_pc + 12'd4;
      GRP_SKIP_REQ: if (vx == vy) npc = model_pc + 12'd4;
      GRP_SKIP_RNE: if (vx != vy) npc = model_pc + 12'd4;
      GRP_LOAD: begin
        wr  = 1'b1;
        val = nn;
      end
      GRP_ADD: begin
        wr  = 1'b1;
        val = vx + nn;
      end
      GRP_ALU: begin
        wr = 1'b1;
        case (n)
          ALU_MOV: val = vy;
          ALU_OR:  val = vx | vy;
          ALU_AND: val = vx & vy;
          ALU_XOR: val = vx ^ vy;
          ALU_ADD: begin
            sum  = {1'b0, vx} + {1'b0, vy};
            val  = sum[DATA_W-1:0];
            fwr  = 1'b1;
            flag = {7'd0, sum[DATA_W]};
          end
          ALU_SUB: begin
            val  = vx - vy;
            fwr  = 1'b1;
            flag = {7'd0, vx >= vy};
          end
          ALU_SHR: begin
            val  = vy >> 1;
            fwr  = 1'b1;
            flag = {7'd0, vy[0]};
          end
          ALU_SUBN: begin
            val  = vy - vx;
            fwr  = 1'b1;
            flag = {7'd0, vy >= vx};
          end
          ALU_SHL: begin
            val  = vy << 1;
            fwr  = 1'b1;
            flag = {7'd0, vy[7]};
          end
          default: begin
            wr    = 1'b0;
            unsup = 1'b1;
          end
        endcase
      end
      GRP_LOAD_I:  model_i = nnn;
      GRP_JUMP_V0: npc = nnn + {4'd0, model_v[REG_V0]};
      GRP_RAND: begin
        wr  = 1'b1;
        val = ((rnd == RAND_MOD) ? 8'h00 : rnd) & nn;
      end
      GRP_MISC: begin
        if (nn == MISC_GET_DELAY) begin
          wr  = 1'b1;
          val = model_delay;
        end else if (nn == MISC_SET_DELAY) begin
          model_delay = vx;
        end else begin
          unsup = 1'b1;
        end
      end
      default: unsup = 1'b1;
    endcase
    if (wr) model_v[x] = val;
    if (fwr) model_v[REG_VF] = flag;
    model_pc = npc;
    if (model_delay != 0) model_delay = model_delay - 8'd1;
    res.next_pc       = model_pc;
    res.reg_write     = wr;
    res.reg_index     = x;
    res.reg_value     = wr ? val : 8'h00;
    res.flag_value    = model_v[REG_VF];
    res.address_value = model_i;
    res.timer_value   = model_delay;
    res.unsupported   = unsup;
    return res;
  endfunction

  // predict on every accepted instruction
  always @(posedge clk) begin
    exec_result_t res;
    if (rst) begin
      model_pc    = ADDR_W'(512);
      model_i     = '0;
      model_delay = '0;
      for (int k = 0; k < REG_CNT; k++) model_v[k] = '0;
    end else if (in_valid && in_ready) begin
      res = execute_opcode(opcode, rand_byte);
      if (typed_valid) res = typed_result;
      exec_results_q.push_back(res);
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    exec_result_t got;
    exec_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {next_pc, reg_write, reg_index, reg_value, flag_value, address_value,
             timer_value, unsupported};
      if (exec_results_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected result transaction pc=%h", next_pc);
      end else begin
        want = exec_results_q.pop_front();
        if (got.next_pc != want.next_pc || got.reg_write != want.reg_write ||
            got.reg_index != want.reg_index || got.reg_value != want.reg_value ||
            got.flag_value != want.flag_value ||
            got.address_value != want.address_value ||
            got.timer_value != want.timer_value ||
            got.unsupported != want.unsupported) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("ERROR: exp pc=%h wr=%b idx=%h val=%h vf=%h i=%h dt=%h unsup=%b",
                     want.next_pc, want.reg_write, want.reg_index, want.reg_value,
                     want.flag_value, want.address_value, want.timer_value,
                     want.unsupported);
            $display("       got pc=%h wr=%b idx=%h val=%h vf=%h i=%h dt=%h unsup=%b",
                     got.next_pc, got.reg_write, got.reg_index, got.reg_value,
                     got.flag_value, got.address_value, got.timer_value,
                     got.unsupported);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("chip8_instruction_execute test failed");
        $finish;
      end
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
        @(negedge clk);
      end
    end
  end

  task automatic send_txn(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] rnd);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle) @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    rand_byte <= rnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : main
    stim_row_t         dir_tab[$];
    logic [3:0]        grp;
    logic [3:0]        x;
    logic [3:0]        y;
    logic [3:0]        n;
    logic [7:0]        lo;
    logic [DATA_W-1:0] rnd;
    int                r;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = '0;
    rand_byte    = '0;
    typed_valid  = 1'b0;
    typed_result = '0;
    err_cnt      = 0;
    idle_cycles  = 0;
    send_idle    = 21;
    recv_idle    = 45;
    hold_req     = 1'b0;
    hold_done    = 1'b0;

    dir_tab.push_back('{16'h00E0, 8'h00, 1'b1,
                        '{12'h202, 1'b0, 4'h0, 8'h00, 8'h00, 12'h000, 8'h00, 1'b1}});
    dir_tab.push_back('{16'h6FFF, 8'h00, 1'b1,
                        '{12'h204, 1'b1, 4'hF, 8'hFF, 8'hFF, 12'h000, 8'h00, 1'b0}});
    dir_tab.push_back('{16'h60FF, 8'hFF, 1'b1,
                        '{12'h206, 1'b1, 4'h0, 8'hFF, 8'hFF, 12'h000, 8'h00, 1'b0}});
    dir_tab.push_back('{16'h6101, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8014, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8105, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8015, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8016, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h801E, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8F17, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8121, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8122, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8123, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8120, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h8019, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h3000, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h4001, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h501F, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h901F, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hAFFF, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hBFFF, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hC0FF, 8'hFF, 1'b0, '0});
    dir_tab.push_back('{16'hC1FF, 8'hFE, 1'b0, '0});
    dir_tab.push_back('{16'h6E09, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hFE15, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hF207, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hF0FF, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'h1FFE, 8'h00, 1'b0, '0});
    dir_tab.push_back('{16'hD123, 8'h00, 1'b0, '0});

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      typed_valid  = dir_tab[k].typed;
      typed_result = dir_tab[k].want;
      send_txn(dir_tab[k].op, dir_tab[k].rnd);
    end
    typed_valid = 1'b0;

    for (int i = 0; i < N_RAND; i++) begin
      if (i < N_RAND / 3) begin
        send_idle = 21;
        recv_idle = 45;
      end else if (i < 2 * N_RAND / 3) begin
        send_idle = 45;
        recv_idle = 21;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (i == 2 * N_RAND / 3 + 20) hold_req = 1'b1;

      x   = 4'($urandom_range(0, 15));
      y   = 4'($urandom_range(0, 15));
      n   = 4'($urandom_range(0, 15));
      rnd = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      grp = 4'($urandom_range(0, 15));
      if ((grp == 4'h0 || grp == 4'h2 || grp == 4'hD || grp == 4'hE) &&
          $urandom_range(0, 1) == 1) grp = GRP_ALU;
      case (grp)
        GRP_SKIP_REQ, GRP_SKIP_RNE: if ($urandom_range(0, 1) == 1) y = x;
        GRP_ALU: begin
          if ($urandom_range(0, 9) != 0) begin
            r = $urandom_range(0, 8);
            n = (r == 8) ? ALU_SHL : 4'(r);
          end
        end
        default: ;
      endcase
      lo = {y, n};
      case (grp)
        GRP_SKIP_EQ, GRP_SKIP_NE: if ($urandom_range(0, 1) == 1) lo = model_v[x];
        GRP_MISC: begin
          r = $urandom_range(0, 9);
          if (r < 4) lo = MISC_GET_DELAY;
          else if (r < 8) lo = MISC_SET_DELAY;
        end
        default: ;
      endcase
      if ($urandom_range(0, 99) < 8) send_txn(16'($urandom_range(0, 65535)), rnd);
      else send_txn({grp, x, lo}, rnd);
    end
    in_valid <= 1'b0;

    while (exec_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("chip8_instruction_execute test passed");
    end else begin
      $display("chip8_instruction_execute test failed");
    end
    $finish;
  end

endmodule
